>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rfu_pkg.sv
// types, constants and helper functions of the rle frame unpacker
`timescale 1ns / 1ps

package rfu_pkg;

    localparam int PIXEL_COUNT_BITS = 20;
    localparam int CMP_BITS = (PIXEL_COUNT_BITS > 9) ? PIXEL_COUNT_BITS : 9;

    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_BITS = $clog2(JOB_DEPTH);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);

    localparam logic [7:0] SKIP_CODE = 8'd254;
    localparam logic [7:0] RAMP_STEP = 8'd18;
    localparam logic [7:0] RAMP_TOP  = 8'd15;
    localparam logic [7:0] RAMP_MAX  = 8'd255;

    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    localparam logic [1:0] MODE_PALETTE = 2'd0;
    localparam logic [1:0] MODE_ALPHA   = 2'd1;

    typedef enum logic [2:0] {
        REG_RUN_MARKER         = 3'd0,
        REG_FRAME_PIXELS       = 3'd1,
        REG_PIXEL_MODE         = 3'd2,
        REG_TRANSPARENT_COLOR  = 3'd3,
        REG_CODE_MARKER_KEY    = 3'd4,
        REG_CODE_HIGHBIT_KEY   = 3'd5,
        REG_CODE_MARKER_DELTA  = 3'd6,
        REG_CODE_HIGHBIT_DELTA = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic        op;
        logic [7:0]  byte_value;
        logic [7:0]  palette_index;
        logic [23:0] palette_color;
    } item_t;

    typedef struct packed {
        logic [31:0] pixel_word;
        logic [8:0]  run_length;
        logic        skip;
        logic        frame_end;
        logic        bad_method;
    } result_t;

    typedef struct packed {
        logic [7:0]  run_marker;
        logic [19:0] frame_pixels;
        logic [1:0]  pixel_mode;
        logic [23:0] transparent_color;
        logic [7:0]  code_marker_key;
        logic [7:0]  code_highbit_key;
        logic [7:0]  code_marker_delta;
        logic [7:0]  code_highbit_delta;
    } cfg_t;

    typedef struct packed {
        logic        wr;
        logic [7:0]  index;
        logic [23:0] color;
        logic [8:0]  run_length;
        logic        skip;
        logic        frame_end;
        logic        bad_method;
        logic        zero_word;
    } job_t;

    function automatic logic [7:0] alpha_ramp(input logic [7:0] idx);
        logic [7:0] val;
        if (idx > RAMP_TOP)
        begin
            val = RAMP_MAX;
        end
        else if (idx == RAMP_TOP)
        begin
            val = RAMP_STEP;
        end
        else
        begin
            val = 8'(idx * RAMP_STEP);
        end
        return val;
    endfunction

endpackage

>>> src/rfu_front.sv
// front end: parses packed bytes, turns each literal or run into a job and passes palette writes on as jobs
`timescale 1ns / 1ps

module rfu_front (
    input  logic           clk,
    input  logic           rst_n,
    input  rfu_pkg::cfg_t  cfg,
    input  logic           push,
    input  rfu_pkg::item_t item,
    output logic           full,
    output logic           job_push,
    output rfu_pkg::job_t  job,
    input  logic           job_full
);
    import rfu_pkg::*;

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_DATA,
        PH_MCOUNT,
        PH_MVALUE,
        PH_HVALUE
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [1:0]                  kind_reg, kind_next;
    logic [PIXEL_COUNT_BITS-1:0] pixels_left_reg, pixels_left_next;
    logic [8:0]                  pending_reg, pending_next;

    logic                        accept;
    logic [7:0]                  b;
    logic                        matched;
    logic [PIXEL_COUNT_BITS-1:0] pl_init;
    logic                        emit;
    logic [7:0]                  emit_value;
    logic [8:0]                  emit_count;
    logic [8:0]                  clip_count;
    logic [PIXEL_COUNT_BITS-1:0] left_after;

    assign full    = job_full;
    assign accept  = push && !job_full;
    assign b       = item.byte_value;
    assign pl_init = PIXEL_COUNT_BITS'(cfg.frame_pixels);

    always_comb
    begin
        phase_next       = phase_reg;
        kind_next        = kind_reg;
        pixels_left_next = pixels_left_reg;
        pending_next     = pending_reg;
        job_push         = 1'b0;
        job              = '0;
        matched          = 1'b1;
        emit             = 1'b0;
        emit_value       = b;
        emit_count       = 9'd1;
        clip_count       = 9'd0;
        left_after       = '0;

        if (accept)
        begin
            if (item.op == OP_PALETTE)
            begin
                job_push  = 1'b1;
                job.wr    = 1'b1;
                job.index = item.palette_index;
                job.color = item.palette_color;
            end
            else
            begin
                case (phase_reg)
                    PH_METHOD:
                    begin
                        if (b == cfg.code_marker_key)
                            kind_next = 2'd0;
                        else if (b == cfg.code_highbit_key)
                            kind_next = 2'd1;
                        else if (b == cfg.code_marker_delta)
                            kind_next = 2'd2;
                        else if (b == cfg.code_highbit_delta)
                            kind_next = 2'd3;
                        else
                            matched = 1'b0;

                        if (!matched)
                        begin
                            job_push       = 1'b1;
                            job.bad_method = 1'b1;
                            job.zero_word  = 1'b1;
                        end
                        else if (pl_init == '0)
                        begin
                            pixels_left_next = '0;
                            job_push         = 1'b1;
                            job.frame_end    = 1'b1;
                            job.zero_word    = 1'b1;
                        end
                        else
                        begin
                            pixels_left_next = pl_init;
                            phase_next       = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        if (kind_reg[0])
                        begin
                            if (!b[7])
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                pending_next = {2'b00, b[6:0]};
                                phase_next   = PH_HVALUE;
                            end
                        end
                        else if (b != cfg.run_marker)
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_MCOUNT;
                        end
                    end
                    PH_MCOUNT:
                    begin
                        if (b < 8'd2)
                        begin
                            emit       = 1'b1;
                            emit_value = cfg.run_marker;
                            emit_count = {1'b0, b} + 9'd1;
                        end
                        else
                        begin
                            pending_next = {1'b0, b} + 9'd1;
                            phase_next   = PH_MVALUE;
                        end
                    end
                    PH_MVALUE, PH_HVALUE:
                    begin
                        emit       = 1'b1;
                        emit_count = pending_reg;
                    end
                    default:
                    begin
                        phase_next = PH_METHOD;
                    end
                endcase
            end
        end

        if (emit)
        begin
            // clip the run to what is left of the frame
            if (CMP_BITS'(emit_count) > CMP_BITS'(pixels_left_reg))
                clip_count = 9'(pixels_left_reg);
            else
                clip_count = emit_count;
            left_after = PIXEL_COUNT_BITS'(CMP_BITS'(pixels_left_reg) - CMP_BITS'(clip_count));

            job_push         = 1'b1;
            job.index        = emit_value;
            job.run_length   = clip_count;
            job.skip         = kind_reg[1] && (emit_value == SKIP_CODE);
            job.zero_word    = kind_reg[1] && (emit_value == SKIP_CODE);
            job.frame_end    = (left_after == '0);
            pixels_left_next = left_after;
            phase_next       = (left_after == '0) ? PH_METHOD : PH_DATA;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_METHOD;
            kind_reg        <= 2'd0;
            pixels_left_reg <= '0;
            pending_reg     <= 9'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            kind_reg        <= kind_next;
            pixels_left_reg <= pixels_left_next;
            pending_reg     <= pending_next;
        end
    end

endmodule

>>> src/rfu_queue.sv
// short job queue between the front end and the back end
`timescale 1ns / 1ps

module rfu_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rfu_pkg::job_t job_in,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output rfu_pkg::job_t job_out
);
    import rfu_pkg::*;

    job_t                  entry_reg [JOB_DEPTH];
    logic [JOB_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JOB_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JOB_PTR_BITS:0]   count_reg, count_next;
    logic                    do_push;
    logic                    do_pop;

    assign full    = (count_reg == (JOB_PTR_BITS+1)'(JOB_DEPTH));
    assign valid   = (count_reg != '0);
    assign job_out = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= job_in;
    end

endmodule

>>> src/rfu_back.sv
// back end: palette store, colour lookup and result queue
`timescale 1ns / 1ps

module rfu_back (
    input  logic             clk,
    input  logic             rst_n,
    input  rfu_pkg::cfg_t    cfg,
    input  logic             job_valid,
    input  rfu_pkg::job_t    job,
    output logic             job_pop,
    input  logic             pop,
    output logic             empty,
    output rfu_pkg::result_t result
);
    import rfu_pkg::*;

    logic [23:0]             palette_mem [256];
    logic [23:0]             rd_data_reg;
    logic                    stage_valid_reg;
    job_t                    stage_job_reg;

    result_t                 out_mem [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0] out_wr_ptr_reg;
    logic [OUT_PTR_BITS-1:0] out_rd_ptr_reg;
    logic [OUT_PTR_BITS:0]   out_count_reg, out_count_next;

    logic                    space;
    logic                    lookup;
    logic                    out_push;
    logic                    out_pop;
    result_t                 out_item;

    // room for the result in flight plus a new one
    assign space   = ((out_count_reg + {{OUT_PTR_BITS{1'b0}}, stage_valid_reg})
                      < (OUT_PTR_BITS+1)'(OUT_DEPTH));
    assign job_pop = job_valid && (job.wr || space);
    assign lookup  = job_pop && !job.wr;

    always_ff @(posedge clk)
    begin
        if (job_pop && job.wr)
            palette_mem[job.index] <= job.color;
        if (lookup)
            rd_data_reg <= palette_mem[job.index];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= lookup;
    end

    always_ff @(posedge clk)
    begin
        if (lookup)
            stage_job_reg <= job;
    end

    always_comb
    begin
        out_item            = '0;
        out_item.run_length = stage_job_reg.run_length;
        out_item.skip       = stage_job_reg.skip;
        out_item.frame_end  = stage_job_reg.frame_end;
        out_item.bad_method = stage_job_reg.bad_method;
        if (!stage_job_reg.zero_word)
        begin
            case (cfg.pixel_mode)
                MODE_PALETTE:
                begin
                    if (rd_data_reg == cfg.transparent_color)
                        out_item.pixel_word = 32'd0;
                    else
                        out_item.pixel_word = {8'hFF, rd_data_reg};
                end
                MODE_ALPHA:
                begin
                    out_item.pixel_word = {24'd0, alpha_ramp(stage_job_reg.index)};
                end
                default:
                begin
                    out_item.pixel_word = {24'd0, stage_job_reg.index};
                end
            endcase
        end
    end

    assign out_push = stage_valid_reg;
    assign empty    = (out_count_reg == '0);
    assign out_pop  = pop && !empty;
    assign result   = out_mem[out_rd_ptr_reg];

    always_comb
    begin
        out_count_next = out_count_reg;
        if (out_push && !out_pop)
            out_count_next = out_count_reg + 1'b1;
        else if (out_pop && !out_push)
            out_count_next = out_count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (out_push)
                out_wr_ptr_reg <= out_wr_ptr_reg + 1'b1;
            if (out_pop)
                out_rd_ptr_reg <= out_rd_ptr_reg + 1'b1;
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
            out_mem[out_wr_ptr_reg] <= out_item;
    end

endmodule

>>> src/rle_frame_unpacker_core.sv
// path: a result reaches the result ports through the job queue, the palette lookup stage and the result queue
// throughput: one item per cycle while full is low, set by the single palette read port of the back end
// the front end parses one byte per cycle, while the job queue is not full, into a four-entry job queue
// the back end buffers up to four results so push continues while pop stalls
// reset: async active low, clears control state and config; the palette store is not cleared
`timescale 1ns / 1ps

module rle_frame_unpacker_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rfu_pkg::item_t   item,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output rfu_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rfu_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_write;
    reg_index_t reg_sel;

    logic       job_push;
    job_t       job_in;
    logic       job_full;
    logic       job_valid;
    job_t       job_head;
    logic       job_pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_marker         <= 8'd238;
            cfg_reg.frame_pixels       <= 20'd1024;
            cfg_reg.pixel_mode         <= 2'd0;
            cfg_reg.transparent_color  <= 24'd0;
            cfg_reg.code_marker_key    <= 8'd1;
            cfg_reg.code_highbit_key   <= 8'd3;
            cfg_reg.code_marker_delta  <= 8'd0;
            cfg_reg.code_highbit_delta <= 8'd2;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_RUN_MARKER:         cfg_reg.run_marker         <= pwdata[7:0];
                REG_FRAME_PIXELS:       cfg_reg.frame_pixels       <= pwdata[19:0];
                REG_PIXEL_MODE:         cfg_reg.pixel_mode         <= pwdata[1:0];
                REG_TRANSPARENT_COLOR:  cfg_reg.transparent_color  <= pwdata[23:0];
                REG_CODE_MARKER_KEY:    cfg_reg.code_marker_key    <= pwdata[7:0];
                REG_CODE_HIGHBIT_KEY:   cfg_reg.code_highbit_key   <= pwdata[7:0];
                REG_CODE_MARKER_DELTA:  cfg_reg.code_marker_delta  <= pwdata[7:0];
                REG_CODE_HIGHBIT_DELTA: cfg_reg.code_highbit_delta <= pwdata[7:0];
                default:                cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_RUN_MARKER:         prdata = {24'd0, cfg_reg.run_marker};
            REG_FRAME_PIXELS:       prdata = {12'd0, cfg_reg.frame_pixels};
            REG_PIXEL_MODE:         prdata = {30'd0, cfg_reg.pixel_mode};
            REG_TRANSPARENT_COLOR:  prdata = {8'd0, cfg_reg.transparent_color};
            REG_CODE_MARKER_KEY:    prdata = {24'd0, cfg_reg.code_marker_key};
            REG_CODE_HIGHBIT_KEY:   prdata = {24'd0, cfg_reg.code_highbit_key};
            REG_CODE_MARKER_DELTA:  prdata = {24'd0, cfg_reg.code_marker_delta};
            REG_CODE_HIGHBIT_DELTA: prdata = {24'd0, cfg_reg.code_highbit_delta};
            default:                prdata = 32'd0;
        endcase
    end

    rfu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .item     (item),
        .full     (full),
        .job_push (job_push),
        .job      (job_in),
        .job_full (job_full)
    );

    rfu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .job_in  (job_in),
        .full    (job_full),
        .pop     (job_pop),
        .valid   (job_valid),
        .job_out (job_head)
    );

    rfu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job_head),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

>>> src/rfu_checker.sv
// port-level checks of the rle frame unpacker and their bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rfu_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input rfu_pkg::result_t result
);

    `ASSERT_IMPLIES(a_bad_method_clean, clk, rst_n, !empty && result.bad_method, result.pixel_word == 32'd0 && result.run_length == 9'd0 && !result.skip && !result.frame_end, "bad method transfer carries nonzero fields")
    `ASSERT_IMPLIES(a_skip_no_color, clk, rst_n, !empty && result.skip, result.pixel_word == 32'd0 && !result.bad_method, "skip transfer carries a colour")
    `ASSERT_ALWAYS(a_run_bound, clk, rst_n, empty || result.run_length <= 9'd256, "run length above 256")
    `ASSERT_NEXT(a_result_held, clk, rst_n, !empty && !pop, !empty && $stable(result), "waiting result changed or vanished")

endmodule

bind rle_frame_unpacker_core rfu_checker u_checker (.*);
